/* src/mxt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mxt_pkg: shared types and constants of the maximum-XOR binary trie
// Sizes of the node store, key and level fields, command and status codes,
// controller state encoding and the control/status bundles.
// ----------------------------------------------------------------------------
package mxt_pkg;

    localparam int MAX_KEY_BITS = 32;
    localparam int NODE_DEPTH   = 1024;

    localparam int VAL_W  = 32;                      // width of value / max_xor
    localparam int KEY_W  = MAX_KEY_BITS;            // working key width
    localparam int KB_W   = 6;                       // key_bits register width
    localparam int CMD_W  = 2;
    localparam int STS_W  = 2;
    localparam int LINK_W = $clog2(NODE_DEPTH);      // child link / node address
    localparam int CNT_W  = $clog2(NODE_DEPTH + 1);  // nodes_used
    localparam int LVL_W  = ($clog2(MAX_KEY_BITS) > 0) ? $clog2(MAX_KEY_BITS) : 1;
    localparam int NODE_W = 2 * LINK_W;              // {link1, link0}

    localparam logic [KB_W-1:0] KEY_BITS_RST = KB_W'(32);

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    localparam logic [STS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STS_W-1:0] ST_EMPTY = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_WALK  = 4'b0010,
        S_ALLOC = 4'b0100,
        S_RESP  = 4'b1000
    } t_state;

    typedef struct packed {
        logic load;      // latch a new item
        logic clear;     // empty the trie
        logic cfg_wr;    // write key_bits (also empties the trie)
        logic walk;      // one trie level using the current node
        logic alloc;     // one level of a freshly allocated path
        logic out_load;  // move the result into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic full;      // an insert now would be rejected
        logic empty;     // no root children
        logic last;      // working on bit 0
        logic to_alloc;  // insert missed above bit 0, rest of path is new
        logic stop;      // walk finishes this cycle
    } t_dp_sts;

    function automatic logic [KEY_W-1:0] fit_key(input logic [VAL_W-1:0] v);
        logic [KEY_W-1:0] k;
        k = '0;
        for (int i = 0; i < KEY_W; i++) begin
            if (i < VAL_W) begin
                k[i] = v[i];
            end
        end
        return k;
    endfunction

    function automatic logic [VAL_W-1:0] fit_val(input logic [KEY_W-1:0] k);
        logic [VAL_W-1:0] v;
        v = '0;
        for (int i = 0; i < VAL_W; i++) begin
            if (i < KEY_W) begin
                v[i] = k[i];
            end
        end
        return v;
    endfunction

endpackage
`default_nettype wire

/* src/mxt_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mxt_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mxt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

/* src/mxt_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mxt_dp: trie datapath
// Node store, root links, allocation counter, key/level/cursor registers,
// result accumulation and the output payload register.
// ----------------------------------------------------------------------------
module mxt_dp (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire mxt_pkg::t_dp_cmd         i_cmd_ctl,
    output mxt_pkg::t_dp_sts              o_sts,
    input  wire logic [mxt_pkg::CMD_W-1:0] i_cmd,
    input  wire logic [mxt_pkg::VAL_W-1:0] i_value,
    input  wire logic [mxt_pkg::KB_W-1:0]  i_cfg_data,
    output logic      [mxt_pkg::VAL_W-1:0] o_max_xor,
    output logic      [mxt_pkg::STS_W-1:0] o_status
);

    import mxt_pkg::*;

    localparam int SUM_W = CNT_W + 1;

    // control state
    logic [KB_W-1:0]   r_key_bits;
    logic [CNT_W-1:0]  r_nodes_used;
    logic [LINK_W-1:0] r_root_link [2];
    logic              r_at_root;

    // item payload
    logic [KEY_W-1:0]  r_key;
    logic [CMD_W-1:0]  r_op;
    logic [LVL_W-1:0]  r_lvl;
    logic [LINK_W-1:0] r_cur;
    logic [KEY_W-1:0]  r_res;
    logic [STS_W-1:0]  r_status;

    logic [LVL_W-1:0]  eff_m1;
    logic              full;
    logic              empty;
    logic [SUM_W-1:0]  need;

    logic [LINK_W-1:0] kid0, kid1, link_b, link_o, new_link;
    logic [LINK_W-1:0] n_cur;
    logic              b, has_b, has_o, is_ins;

    logic              ram_we;
    logic [NODE_W-1:0] ram_wdata, ram_rdata;

    // effective width minus one: 0 acts as 1, above the maximum clamps
    always_comb begin
        if (r_key_bits == '0) begin
            eff_m1 = '0;
        end else if (int'(r_key_bits) > MAX_KEY_BITS) begin
            eff_m1 = LVL_W'(MAX_KEY_BITS - 1);
        end else begin
            eff_m1 = LVL_W'(r_key_bits - 1'b1);
        end
    end

    // reject when a whole new path might not fit
    assign need  = SUM_W'(r_nodes_used) + SUM_W'(eff_m1) + SUM_W'(1);
    assign full  = need > SUM_W'(NODE_DEPTH);
    assign empty = (r_root_link[0] == '0) && (r_root_link[1] == '0);

    always_comb begin
        kid0     = r_at_root ? r_root_link[0] : ram_rdata[LINK_W-1:0];
        kid1     = r_at_root ? r_root_link[1] : ram_rdata[NODE_W-1:LINK_W];
        b        = r_key[r_lvl];
        link_b   = b ? kid1 : kid0;
        link_o   = b ? kid0 : kid1;
        has_b    = link_b != '0;
        has_o    = link_o != '0;
        is_ins   = r_op == CMD_INSERT;
        new_link = r_nodes_used[LINK_W-1:0];

        n_cur     = r_cur;
        ram_we    = 1'b0;
        ram_wdata = '0;
        if (i_cmd_ctl.walk) begin
            if (is_ins) begin
                if (has_b) begin
                    n_cur = link_b;
                end else begin
                    n_cur = new_link;
                    if (!r_at_root) begin
                        ram_we    = 1'b1;
                        ram_wdata = b ? {new_link, kid0} : {kid1, new_link};
                    end
                end
            end else if (has_o) begin
                n_cur = link_o;
            end else if (has_b) begin
                n_cur = link_b;
            end
        end else if (i_cmd_ctl.alloc) begin
            // fresh node: only the branch along the key exists
            ram_we    = 1'b1;
            ram_wdata = b ? {new_link, {LINK_W{1'b0}}} : {{LINK_W{1'b0}}, new_link};
            n_cur     = new_link;
        end
    end

    always_comb begin
        o_sts.full     = full;
        o_sts.empty    = empty;
        o_sts.last     = r_lvl == '0;
        o_sts.to_alloc = is_ins && !has_b && (r_lvl != '0);
        o_sts.stop     = (r_lvl == '0) || (!is_ins && !has_o && !has_b);
    end

    // read address follows the next cursor so its children arrive next cycle
    mxt_ram #(
        .WIDTH (NODE_W),
        .DEPTH (NODE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_cur),
        .i_wdata (ram_wdata),
        .i_raddr (n_cur),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_bits     <= KEY_BITS_RST;
            r_nodes_used   <= CNT_W'(1);
            r_root_link[0] <= '0;
            r_root_link[1] <= '0;
            r_at_root      <= 1'b1;
        end else begin
            if (i_cmd_ctl.cfg_wr) begin
                r_key_bits <= i_cfg_data;
            end
            if (i_cmd_ctl.clear || i_cmd_ctl.cfg_wr) begin
                r_nodes_used   <= CNT_W'(1);
                r_root_link[0] <= '0;
                r_root_link[1] <= '0;
            end else if (i_cmd_ctl.walk && is_ins && !has_b) begin
                r_nodes_used <= r_nodes_used + 1'b1;
                if (r_at_root) begin
                    r_root_link[b] <= new_link;
                end
            end else if (i_cmd_ctl.alloc) begin
                r_nodes_used <= r_nodes_used + 1'b1;
            end
            if (i_cmd_ctl.load) begin
                r_at_root <= 1'b1;
            end else if (i_cmd_ctl.walk) begin
                r_at_root <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_ctl.load) begin
            r_key <= fit_key(i_value);
            r_op  <= i_cmd;
            r_lvl <= eff_m1;
            r_cur <= '0;
            r_res <= '0;
            if (i_cmd == CMD_INSERT && full) begin
                r_status <= ST_FULL;
            end else if (i_cmd == CMD_QUERY && empty) begin
                r_status <= ST_EMPTY;
            end else begin
                r_status <= ST_OK;
            end
        end else if (i_cmd_ctl.walk || i_cmd_ctl.alloc) begin
            r_cur <= n_cur;
            r_lvl <= r_lvl - 1'b1;
            if (i_cmd_ctl.walk && !is_ins && has_o) begin
                r_res[r_lvl] <= 1'b1;
            end
        end
        if (i_cmd_ctl.out_load) begin
            o_max_xor <= fit_val(r_res);
            o_status  <= r_status;
        end
    end

endmodule
`default_nettype wire

/* src/mxt_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mxt_ctrl: trie controller
// Sequences accept, per-level walk, path allocation and result hand-off;
// owns the handshakes of the input, output and configuration channels.
// ----------------------------------------------------------------------------
module mxt_ctrl (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic [mxt_pkg::CMD_W-1:0] i_cmd,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    output mxt_pkg::t_dp_cmd               o_cmd_ctl,
    input  wire mxt_pkg::t_dp_sts          i_sts
);

    import mxt_pkg::*;

    t_state r_state, n_state;
    logic   out_free;

    assign out_free    = !o_out_valid || !i_out_stall;
    // a pending config write takes the idle cycle ahead of any item
    assign o_in_stall  = (r_state != S_IDLE) || i_cfg_valid;
    assign o_cfg_ready = r_state == S_IDLE;

    always_comb begin
        n_state   = r_state;
        o_cmd_ctl = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd_ctl.cfg_wr = i_cfg_valid;
                if (i_in_valid && !i_cfg_valid) begin
                    o_cmd_ctl.load = 1'b1;
                    case (i_cmd)
                        CMD_INSERT: n_state = i_sts.full ? S_RESP : S_WALK;
                        CMD_QUERY:  n_state = i_sts.empty ? S_RESP : S_WALK;
                        CMD_CLEAR: begin
                            o_cmd_ctl.clear = 1'b1;
                            n_state         = S_RESP;
                        end
                        default:    n_state = S_RESP;
                    endcase
                end
            end
            S_WALK: begin
                o_cmd_ctl.walk = 1'b1;
                if (i_sts.to_alloc) begin
                    n_state = S_ALLOC;
                end else if (i_sts.stop) begin
                    n_state = S_RESP;
                end
            end
            S_ALLOC: begin
                o_cmd_ctl.alloc = 1'b1;
                if (i_sts.last) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    o_cmd_ctl.out_load = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd_ctl.out_load) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

/* src/max_xor_binary_trie.sv */
`default_nettype none
// Timing: insert and query walk the trie one level per cycle through the node store
//   read port; clear, rejected insert, empty query and unused cmd skip the walk.
// Items: a new item is taken only once the previous one has moved its result into
//   the output register; the input stalls while an item is in flight.
// Reset: synchronous, active low; trie empty, key_bits = 32, no clearing pass.
// ----------------------------------------------------------------------------
// max_xor_binary_trie: binary trie with maximum-XOR query
// Insert/query/clear on a trie of key_bits-wide keys kept in a node RAM.
// ----------------------------------------------------------------------------
module max_xor_binary_trie (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic [mxt_pkg::CMD_W-1:0] i_cmd,
    input  wire logic [mxt_pkg::VAL_W-1:0] i_value,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic      [mxt_pkg::VAL_W-1:0] o_max_xor,
    output logic      [mxt_pkg::STS_W-1:0] o_status,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [mxt_pkg::KB_W-1:0]  i_cfg_data
);

    import mxt_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    mxt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cmd       (i_cmd),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .o_cmd_ctl   (dp_cmd),
        .i_sts       (dp_sts)
    );

    mxt_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_ctl  (dp_cmd),
        .o_sts      (dp_sts),
        .i_cmd      (i_cmd),
        .i_value    (i_value),
        .i_cfg_data (i_cfg_data),
        .o_max_xor  (o_max_xor),
        .o_status   (o_status)
    );

endmodule
`default_nettype wire
